// File: rtl/frsm_pkg.sv
package frsm_pkg;

    localparam int RATE_W    = 28;
    localparam int PERIOD_W  = 20;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 28;
    localparam int STEP_W    = 5;
    localparam int WIDE_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING = 2'd1;

    localparam logic [RATE_W-1:0] RATE_SCALE     = 28'd256000000;
    localparam logic [RATE_W-1:0] RESET_TARGET   = 28'd15360;
    localparam logic [RATE_W-1:0] RESET_WARNING  = 28'd7680;
    localparam logic [RATE_W-1:0] RESET_LOWEST   = 28'd255744;
    localparam logic [RATE_W-1:0] LEVEL_SMOOTH   = 28'd14080;
    localparam logic [RATE_W-1:0] LEVEL_STABLE   = 28'd11520;
    localparam logic [RATE_W-1:0] LEVEL_UNSTABLE = 28'd7680;

    typedef enum logic [1:0] {
        QUAL_SMOOTH   = 2'd0,
        QUAL_STABLE   = 2'd1,
        QUAL_UNSTABLE = 2'd2,
        QUAL_POOR     = 2'd3
    } quality_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATE,
        ST_UPDATE,
        ST_DIV_MEAN,
        ST_APPLY,
        ST_FLAGS
    } frsm_state_t;

    typedef struct packed {
        logic start_rate;
        logic step;
        logic update;
        logic apply;
        logic load_out;
    } frsm_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_last;
        logic out_free;
    } frsm_status_t;

endpackage

// File: rtl/frsm_ctrl.sv
module frsm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  frsm_pkg::frsm_status_t status,
    output logic                   in_stall,
    output frsm_pkg::frsm_cmd_t    cmd
);

    frsm_pkg::frsm_state_t state_reg;
    frsm_pkg::frsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frsm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frsm_pkg::ST_IDLE:
            begin
                if (in_valid && !status.period_zero)
                begin
                    state_next = frsm_pkg::ST_DIV_RATE;
                end
            end
            frsm_pkg::ST_DIV_RATE:
            begin
                if (status.div_last)
                begin
                    state_next = frsm_pkg::ST_UPDATE;
                end
            end
            frsm_pkg::ST_UPDATE:
            begin
                state_next = frsm_pkg::ST_DIV_MEAN;
            end
            frsm_pkg::ST_DIV_MEAN:
            begin
                if (status.div_last)
                begin
                    state_next = frsm_pkg::ST_APPLY;
                end
            end
            frsm_pkg::ST_APPLY:
            begin
                state_next = frsm_pkg::ST_FLAGS;
            end
            frsm_pkg::ST_FLAGS:
            begin
                if (status.out_free)
                begin
                    state_next = frsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            frsm_pkg::ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.start_rate = in_valid && !status.period_zero;
            end
            frsm_pkg::ST_DIV_RATE:
            begin
                cmd.step = 1'b1;
            end
            frsm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            frsm_pkg::ST_DIV_MEAN:
            begin
                cmd.step = 1'b1;
            end
            frsm_pkg::ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            frsm_pkg::ST_FLAGS:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/frsm_dp.sv
module frsm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  frsm_pkg::frsm_cmd_t                 cmd,
    output frsm_pkg::frsm_status_t              status,
    input  logic                                cfg_wr_en,
    input  logic [frsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frsm_pkg::RATE_W-1:0]         cfg_data,
    input  logic [frsm_pkg::PERIOD_W-1:0]       period_us,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [frsm_pkg::RATE_W-1:0]         rate_now,
    output logic [frsm_pkg::RATE_W-1:0]         rate_low,
    output logic [frsm_pkg::RATE_W-1:0]         rate_high,
    output logic [frsm_pkg::RATE_W-1:0]         rate_mean,
    output logic                                warn_flag,
    output logic                                stable_flag,
    output logic [1:0]                          quality_code
);

    logic [frsm_pkg::RATE_W-1:0]  target_reg;
    logic [frsm_pkg::RATE_W-1:0]  warning_reg;
    logic [frsm_pkg::RATE_W-1:0]  rate_reg;
    logic [frsm_pkg::RATE_W-1:0]  low_reg;
    logic [frsm_pkg::RATE_W-1:0]  high_reg;
    logic [frsm_pkg::RATE_W-1:0]  mean_reg;
    logic [frsm_pkg::COUNT_W-1:0] count_reg;
    logic                         mean_up_reg;

    logic [frsm_pkg::RATE_W-1:0]  dvd_reg;
    logic [frsm_pkg::COUNT_W-1:0] dvs_reg;
    logic [frsm_pkg::COUNT_W-1:0] rem_reg;
    logic [frsm_pkg::RATE_W-1:0]  quo_reg;
    logic [frsm_pkg::STEP_W-1:0]  step_cnt_reg;

    logic                         out_valid_reg;
    logic [frsm_pkg::RATE_W-1:0]  rate_now_reg;
    logic [frsm_pkg::RATE_W-1:0]  rate_low_reg;
    logic [frsm_pkg::RATE_W-1:0]  rate_high_reg;
    logic [frsm_pkg::RATE_W-1:0]  rate_mean_reg;
    logic                         warn_reg;
    logic                         stable_reg;
    frsm_pkg::quality_t           quality_reg;

    logic [frsm_pkg::COUNT_W:0]   trial;
    logic [frsm_pkg::COUNT_W:0]   trial_sub;
    logic                         trial_ge;
    logic [frsm_pkg::COUNT_W-1:0] count_next;
    logic [frsm_pkg::RATE_W-1:0]  diff;
    logic                         up;
    logic [frsm_pkg::RATE_W-1:0]  mean_next;
    logic [frsm_pkg::WIDE_W-1:0]  rate_x10;
    logic [frsm_pkg::WIDE_W-1:0]  mean_x10;
    logic [frsm_pkg::WIDE_W-1:0]  target_x9;
    frsm_pkg::quality_t           quality_next;

    assign trial     = {rem_reg, dvd_reg[frsm_pkg::RATE_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign trial_ge  = trial >= {1'b0, dvs_reg};

    assign count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign up         = quo_reg >= mean_reg;
    assign diff       = up ? quo_reg - mean_reg : mean_reg - quo_reg;
    assign mean_next  = mean_up_reg ? mean_reg + quo_reg : mean_reg - quo_reg;

    assign rate_x10  = ({4'b0, rate_reg} << 3) + ({4'b0, rate_reg} << 1);
    assign mean_x10  = ({4'b0, mean_reg} << 3) + ({4'b0, mean_reg} << 1);
    assign target_x9 = ({4'b0, target_reg} << 3) + {4'b0, target_reg};

    always_comb
    begin
        if (mean_reg >= frsm_pkg::LEVEL_SMOOTH)
        begin
            quality_next = frsm_pkg::QUAL_SMOOTH;
        end
        else if (mean_reg >= frsm_pkg::LEVEL_STABLE)
        begin
            quality_next = frsm_pkg::QUAL_STABLE;
        end
        else if (mean_reg >= frsm_pkg::LEVEL_UNSTABLE)
        begin
            quality_next = frsm_pkg::QUAL_UNSTABLE;
        end
        else
        begin
            quality_next = frsm_pkg::QUAL_POOR;
        end
    end

    assign status.period_zero = (period_us == '0);
    assign status.div_last    = (step_cnt_reg == frsm_pkg::STEP_W'(frsm_pkg::DIV_STEPS - 1));
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= frsm_pkg::RESET_TARGET;
            warning_reg   <= frsm_pkg::RESET_WARNING;
            low_reg       <= frsm_pkg::RESET_LOWEST;
            high_reg      <= '0;
            mean_reg      <= '0;
            count_reg     <= '0;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    frsm_pkg::REG_TARGET:  target_reg  <= cfg_data;
                    frsm_pkg::REG_WARNING: warning_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.start_rate || cmd.update)
            begin
                step_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                if (quo_reg < low_reg)
                begin
                    low_reg <= quo_reg;
                end
                if (quo_reg > high_reg)
                begin
                    high_reg <= quo_reg;
                end
                count_reg <= count_next;
            end
            if (cmd.apply)
            begin
                mean_reg <= mean_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_rate)
        begin
            dvd_reg <= frsm_pkg::RATE_SCALE;
            dvs_reg <= {{(frsm_pkg::COUNT_W - frsm_pkg::PERIOD_W){1'b0}}, period_us};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.update)
        begin
            rate_reg    <= quo_reg;
            mean_up_reg <= up;
            dvd_reg     <= diff;
            dvs_reg     <= count_next;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= trial_ge ? trial_sub[frsm_pkg::COUNT_W-1:0]
                                : trial[frsm_pkg::COUNT_W-1:0];
            quo_reg <= {quo_reg[frsm_pkg::RATE_W-2:0], trial_ge};
            dvd_reg <= {dvd_reg[frsm_pkg::RATE_W-2:0], 1'b0};
        end
        if (cmd.load_out)
        begin
            rate_now_reg  <= rate_reg;
            rate_low_reg  <= low_reg;
            rate_high_reg <= high_reg;
            rate_mean_reg <= mean_reg;
            warn_reg      <= rate_reg < warning_reg;
            stable_reg    <= (rate_x10 >= target_x9) && (mean_x10 >= target_x9);
            quality_reg   <= quality_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rate_now     = rate_now_reg;
    assign rate_low     = rate_low_reg;
    assign rate_high    = rate_high_reg;
    assign rate_mean    = rate_mean_reg;
    assign warn_flag    = warn_reg;
    assign stable_flag  = stable_reg;
    assign quality_code = quality_reg;

endmodule

// File: rtl/frame_rate_statistics_monitor.sv
// Frame rate statistics monitor.
// Input channel: one frame period in microseconds per transfer (in_valid, in_stall,
// period_us). A zero period is taken and dropped without a result.
// Output channel: one result per nonzero period (out_valid, out_stall), carrying the
// current rate, lowest, highest and running mean rate in 1/256 fps units, a warning
// flag, a stabilized flag and a quality code.
// Configuration: cfg_wr_en, cfg_index, cfg_data write target_rate (index 0) and
// warning_rate (index 1); write only while the block is idle.
// Operation: a nonzero period is taken and worked through to its result before the next
// period can be taken. One shared restoring divider, one quotient bit per cycle, does
// both divisions (rate, then mean step); further states update the statistics, apply
// the mean step and grade the result.
// Receiver stall: the result holds in the output register; the next item is still
// taken and computed, then waits in the last step until the held result is transferred.
// Reset: target 60 fps, warning 30 fps, lowest 999 fps, highest, mean and count zero.
module frame_rate_statistics_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [frsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frsm_pkg::RATE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [frsm_pkg::PERIOD_W-1:0]  period_us,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [frsm_pkg::RATE_W-1:0]    rate_now,
    output logic [frsm_pkg::RATE_W-1:0]    rate_low,
    output logic [frsm_pkg::RATE_W-1:0]    rate_high,
    output logic [frsm_pkg::RATE_W-1:0]    rate_mean,
    output logic                           warn_flag,
    output logic                           stable_flag,
    output logic [1:0]                     quality_code
);

    frsm_pkg::frsm_cmd_t    cmd;
    frsm_pkg::frsm_status_t status;

    frsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    frsm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .period_us    (period_us),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .rate_now     (rate_now),
        .rate_low     (rate_low),
        .rate_high    (rate_high),
        .rate_mean    (rate_mean),
        .warn_flag    (warn_flag),
        .stable_flag  (stable_flag),
        .quality_code (quality_code)
    );

endmodule

// File: rtl/frsm_checker.sv
module frsm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [frsm_pkg::PERIOD_W-1:0]  period_us,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [frsm_pkg::RATE_W-1:0]    rate_now,
    input logic [frsm_pkg::RATE_W-1:0]    rate_low,
    input logic [frsm_pkg::RATE_W-1:0]    rate_high,
    input logic [frsm_pkg::RATE_W-1:0]    rate_mean
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rate_now) && $stable(rate_mean))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && period_us != '0 |=> in_stall)
        else $error("new transfer taken while a period is in work");

    a_rate_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rate_low <= rate_now && rate_now <= rate_high)
        else $error("current rate outside lowest and highest");

    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rate_low <= rate_mean && rate_mean <= rate_high)
        else $error("mean outside lowest and highest");

endmodule

bind frame_rate_statistics_monitor frsm_checker u_frsm_checker (.*);

// File: tb/sv/frame_rate_statistics_monitor_tb.sv
module frame_rate_statistics_monitor_tb;

    localparam int SETTLE_CYCLES = 70;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_FRAMES  = 200;
    localparam int PHASE_COUNT   = 8;

    localparam logic [frsm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [frsm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [frsm_pkg::RATE_W-1:0]    RATE_TOP     = '1;
    localparam logic [frsm_pkg::PERIOD_W-1:0]  PERIOD_TOP   = '1;

    typedef enum int {MIX_SLOW, MIX_TYPICAL, MIX_FAST, MIX_WIDE} period_mix_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

    typedef struct {
        logic [frsm_pkg::RATE_W-1:0] now;
        logic [frsm_pkg::RATE_W-1:0] low;
        logic [frsm_pkg::RATE_W-1:0] high;
        logic [frsm_pkg::RATE_W-1:0] mean;
        logic                        warn;
        logic                        stable;
        frsm_pkg::quality_t          quality;
    } frame_stats_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [frsm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [frsm_pkg::RATE_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [frsm_pkg::PERIOD_W-1:0]  period_us;
    logic                           out_valid;
    logic                           out_stall;
    logic [frsm_pkg::RATE_W-1:0]    rate_now;
    logic [frsm_pkg::RATE_W-1:0]    rate_low;
    logic [frsm_pkg::RATE_W-1:0]    rate_high;
    logic [frsm_pkg::RATE_W-1:0]    rate_mean;
    logic                           warn_flag;
    logic                           stable_flag;
    logic [1:0]                     quality_code;

    logic [frsm_pkg::RATE_W-1:0]  model_target  = frsm_pkg::RESET_TARGET;
    logic [frsm_pkg::RATE_W-1:0]  model_warning = frsm_pkg::RESET_WARNING;
    logic [frsm_pkg::RATE_W-1:0]  model_rate    = frsm_pkg::RESET_TARGET;
    logic [frsm_pkg::RATE_W-1:0]  model_low     = frsm_pkg::RESET_LOWEST;
    logic [frsm_pkg::RATE_W-1:0]  model_high    = '0;
    logic [frsm_pkg::RATE_W-1:0]  model_mean    = '0;
    logic [frsm_pkg::COUNT_W-1:0] model_count   = '0;

    frame_stats_t expected_frames[$];

    int fail_count     = 0;
    int frames_sent    = 0;
    int empty_periods  = 0;
    int frames_checked = 0;
    int cfg_writes     = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    frame_rate_statistics_monitor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .period_us    (period_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rate_now     (rate_now),
        .rate_low     (rate_low),
        .rate_high    (rate_high),
        .rate_mean    (rate_mean),
        .warn_flag    (warn_flag),
        .stable_flag  (stable_flag),
        .quality_code (quality_code)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit near_target(logic [frsm_pkg::RATE_W-1:0] x,
                                       logic [frsm_pkg::RATE_W-1:0] goal);
        return (longint'(x) * 10) >= (longint'(goal) * 9);
    endfunction

    task automatic predict_frame(input logic [frsm_pkg::PERIOD_W-1:0] p);
        logic [31:0]                 quotient;
        logic [frsm_pkg::RATE_W-1:0] delta;
        frame_stats_t                s;
        if (p == '0)
        begin
            empty_periods++;
            return;
        end
        quotient   = 32'(frsm_pkg::RATE_SCALE) / 32'(p);
        model_rate = quotient[frsm_pkg::RATE_W-1:0];
        if (model_rate < model_low)
            model_low = model_rate;
        if (model_rate > model_high)
            model_high = model_rate;
        if (model_count != '1)
            model_count++;
        if (model_rate >= model_mean)
        begin
            delta      = frsm_pkg::RATE_W'(32'(model_rate - model_mean) / model_count);
            model_mean = model_mean + delta;
        end
        else
        begin
            delta      = frsm_pkg::RATE_W'(32'(model_mean - model_rate) / model_count);
            model_mean = model_mean - delta;
        end
        s.now    = model_rate;
        s.low    = model_low;
        s.high   = model_high;
        s.mean   = model_mean;
        s.warn   = model_rate < model_warning;
        s.stable = near_target(model_rate, model_target) && near_target(model_mean, model_target);
        if (model_mean >= frsm_pkg::LEVEL_SMOOTH)
            s.quality = frsm_pkg::QUAL_SMOOTH;
        else if (model_mean >= frsm_pkg::LEVEL_STABLE)
            s.quality = frsm_pkg::QUAL_STABLE;
        else if (model_mean >= frsm_pkg::LEVEL_UNSTABLE)
            s.quality = frsm_pkg::QUAL_UNSTABLE;
        else
            s.quality = frsm_pkg::QUAL_POOR;
        expected_frames.push_back(s);
        frames_sent++;
    endtask

    task automatic send_period(input logic [frsm_pkg::PERIOD_W-1:0] p);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid  <= 1'b1;
        period_us <= p;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_frame(p);
        burst_left--;
    endtask

    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [frsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frsm_pkg::RATE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            frsm_pkg::REG_TARGET:  model_target  = value;
            frsm_pkg::REG_WARNING: model_warning = value;
            default:               ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [frsm_pkg::RATE_W-1:0] goal,
                              input logic [frsm_pkg::RATE_W-1:0] floor_rate);
        settle_block();
        write_reg(frsm_pkg::REG_TARGET, goal);
        write_reg(frsm_pkg::REG_WARNING, floor_rate);
    endtask

    function automatic logic [frsm_pkg::PERIOD_W-1:0] pick_period(period_mix_t mix);
        if ($urandom_range(0, 31) == 0)
            return '0;
        case (mix)
            MIX_SLOW:    return frsm_pkg::PERIOD_W'($urandom_range(33334, 200000));
            MIX_TYPICAL: return frsm_pkg::PERIOD_W'($urandom_range(4000, 50000));
            MIX_FAST:    return frsm_pkg::PERIOD_W'($urandom_range(1002, 16000));
            default:     return frsm_pkg::PERIOD_W'($urandom_range(0, int'(PERIOD_TOP)));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [frsm_pkg::RATE_W-1:0] want,
                               input logic [frsm_pkg::RATE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        frame_stats_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("result with no pending frame: rate_now %0d", rate_now);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                check_field("rate_now", want.now, rate_now);
                check_field("rate_low", want.low, rate_low);
                check_field("rate_high", want.high, rate_high);
                check_field("rate_mean", want.mean, rate_mean);
                check_field("warn_flag", frsm_pkg::RATE_W'(want.warn),
                            frsm_pkg::RATE_W'(warn_flag));
                check_field("stable_flag", frsm_pkg::RATE_W'(want.stable),
                            frsm_pkg::RATE_W'(stable_flag));
                check_field("quality_code", frsm_pkg::RATE_W'(want.quality),
                            frsm_pkg::RATE_W'(quality_code));
                frames_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : drive_out_stall
        stall_mode_t mode;
        int          span;
        int          run;
        bit          level;
        out_stall = 1'b0;
        level     = 1'b0;
        run       = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(30, 400);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if (run == 0)
                        begin
                            level = !level;
                            run   = $urandom_range(1, 90);
                        end
                        run--;
                        out_stall <= level;
                    end
                endcase
            end
        end
    end

    // lowest rate holds its reset value while every rate is at or above it, then follows a lower rate
    task automatic test_fast_start();
        send_period(20'd1000);
        send_period(20'd900);
        send_period(20'd0);
        send_period(20'd1001);
        send_period(20'd1002);
    endtask

    task automatic test_zero_periods();
        send_period(20'd0);
        send_period(20'd0);
        send_period(20'd16667);
        send_period(20'd0);
        send_period(20'd33333);
    endtask

    task automatic test_long_periods();
        send_period(PERIOD_TOP);
        send_period(20'hAAAAA);
        send_period(20'h55555);
        send_period(20'h80000);
        send_period(20'h7FFFF);
    endtask

    task automatic test_register_writes();
        set_limits(RATE_TOP, '0);
        send_period(20'd16667);
        send_period(20'd20000);
        set_limits('0, RATE_TOP);
        send_period(20'd16667);
        send_period(20'd40000);
        settle_block();
        write_reg(REG_SPARE_LO, RATE_TOP);
        write_reg(REG_SPARE_HI, frsm_pkg::RATE_W'($urandom()));
        send_period(20'd25000);
        set_limits(frsm_pkg::RESET_TARGET, frsm_pkg::RESET_WARNING);
        send_period(20'd17000);
    endtask

    task automatic test_random_phases();
        period_mix_t                 mix;
        logic [frsm_pkg::RATE_W-1:0] goal;
        logic [frsm_pkg::RATE_W-1:0] floor_rate;
        int                          start;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    mix = MIX_SLOW;    goal = frsm_pkg::RESET_TARGET;
                    floor_rate = frsm_pkg::RESET_WARNING;
                end
                1:
                begin
                    mix = MIX_SLOW;    goal = '0;           floor_rate = RATE_TOP;
                end
                2:
                begin
                    mix = MIX_TYPICAL; goal = frsm_pkg::RATE_W'($urandom_range(0, 20000));
                    floor_rate = frsm_pkg::RATE_W'($urandom_range(0, 20000));
                end
                3:
                begin
                    mix = MIX_TYPICAL; goal = RATE_TOP;     floor_rate = '0;
                end
                4:
                begin
                    mix = MIX_FAST;    goal = frsm_pkg::RATE_W'($urandom_range(0, 60000));
                    floor_rate = frsm_pkg::RATE_W'($urandom_range(0, 60000));
                end
                5:
                begin
                    mix = MIX_FAST;    goal = frsm_pkg::RESET_TARGET;
                    floor_rate = frsm_pkg::RESET_WARNING;
                end
                6:
                begin
                    mix = MIX_WIDE;    goal = frsm_pkg::RATE_W'($urandom());
                    floor_rate = frsm_pkg::RATE_W'($urandom());
                end
                default:
                begin
                    mix = MIX_TYPICAL; goal = frsm_pkg::RATE_W'($urandom_range(0, 20000));
                    floor_rate = frsm_pkg::RATE_W'($urandom_range(0, 20000));
                end
            endcase
            set_limits(goal, floor_rate);
            start = frames_sent;
            while (frames_sent - start < PHASE_FRAMES)
                send_period(pick_period(mix));
        end
    endtask

    task automatic test_short_periods();
        send_period(20'd1);
        send_period(20'd2);
        send_period(20'd3);
        send_period(20'd1000);
    endtask

    initial
    begin
        in_valid  = 1'b0;
        period_us = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_fast_start();
        test_zero_periods();
        test_long_periods();
        test_register_writes();
        test_random_phases();
        test_short_periods();
        settle_block();

        $display("covered %0d nonzero and %0d zero frame periods, %0d results checked",
                 frames_sent, empty_periods, frames_checked);
        $display("%0d register writes: reset values, both extremes, random and unused indexes",
                 cfg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
